[rtl/core/rgb_convolution_3x3_assert.svh]
// Assertion macros shared by the convolution block.
`ifndef RGB_CONVOLUTION_3X3_ASSERT_SVH
`define RGB_CONVOLUTION_3X3_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGBC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_convolution_3x3 assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RGBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb_convolution_3x3 assertion failed");

`endif

[rtl/core/rgbc_pkg.sv]
// Package with types, constants and helpers of the convolution block.
package rgbc_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int MAX_HEIGHT     = 4096;
    localparam int COEF_FRAC_BITS = 8;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = 12;
    localparam int HGT_W  = 13;
    localparam int ROW_W  = HGT_W;
    localparam int POS_W  = 24;
    localparam int CFG_W  = 48;
    localparam int IDX_W  = 3;

    localparam int OPQ_DEPTH  = 4;
    localparam int OPQ_AW     = $clog2(OPQ_DEPTH);
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int CRED_W     = $clog2(OUTQ_DEPTH + 1);

    localparam int PROD_W = 25;
    localparam int RSUM_W = 27;
    localparam int SUM_W  = 29;

    typedef enum logic [IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_K_TOP  = 3'd2,
        CFG_K_MID  = 3'd3,
        CFG_K_BOT  = 3'd4
    } t_cfg_idx;

    typedef logic [23:0] t_pix;

    typedef struct packed {
        logic       is_drain;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       end_of_frame;
    } t_out_item;

    typedef struct packed {
        t_pix             px;
        logic [COL_W-1:0] addr;
        logic             emit;
        logic             top;
        logic             bot;
        logic             left;
        logic             right;
        logic             eof;
    } t_op;

    typedef struct packed {
        logic extra;
        logic pos_zero;
    } t_front_stat;

    typedef struct packed {
        logic [CRED_W-1:0] credit;
    } t_back_stat;

    function automatic logic [7:0] clamp_sum(input logic signed [SUM_W-1:0] s);
        logic [7:0] r;
        if (s[SUM_W-1]) begin
            r = 8'd0;
        end else if (|s[SUM_W-2:COEF_FRAC_BITS+8]) begin
            r = 8'd255;
        end else begin
            r = s[COEF_FRAC_BITS +: 8];
        end
        return r;
    endfunction

endpackage

[rtl/core/rgbc_front.sv]
// Front end: accepts items, tracks stream position and classifies each position.
module rgbc_front import rgbc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  t_in_item         i_item,
    input  logic [WID_W-1:0] i_width,
    input  logic [HGT_W-1:0] i_height,
    input  logic             i_restart,
    input  logic             i_q_full,
    output logic             o_q_push,
    output t_op              o_q_op,
    output t_front_stat      o_stat
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [COL_W-1:0] r_ocol, n_ocol;
    logic [ROW_W-1:0] r_orow, n_orow;
    logic             r_extra, n_extra;

    logic [WID_W-1:0] w;
    logic [HGT_W-1:0] h;
    logic             frame_in, accept, is_pos, emit, right, bot;

    always_comb begin
        if (i_width == '0) begin
            w = WID_W'(1);
        end else if (i_width > WID_W'(MAX_WIDTH)) begin
            w = WID_W'(MAX_WIDTH);
        end else begin
            w = i_width;
        end
        if (i_height == '0) begin
            h = HGT_W'(1);
        end else if (i_height > HGT_W'(MAX_HEIGHT)) begin
            h = HGT_W'(MAX_HEIGHT);
        end else begin
            h = i_height;
        end
    end

    assign frame_in = r_row >= h;
    assign full     = r_extra || i_q_full;
    assign accept   = push && !full;
    assign is_pos   = (accept && (i_item.is_drain ? frame_in : !frame_in))
                      || (r_extra && !i_q_full);
    assign emit     = r_pos >= (POS_W'(w) + POS_W'(1));
    assign right    = (WID_W'(r_ocol) + WID_W'(1)) >= w;
    assign bot      = (r_orow + ROW_W'(1)) >= h;

    always_comb begin
        o_q_push     = is_pos && !i_restart;
        o_q_op.px    = (r_extra || i_item.is_drain) ? '0
                       : {i_item.red_in, i_item.green_in, i_item.blue_in};
        o_q_op.addr  = r_col;
        o_q_op.emit  = emit;
        o_q_op.top   = r_orow == '0;
        o_q_op.bot   = bot;
        o_q_op.left  = r_ocol == '0;
        o_q_op.right = right;
        o_q_op.eof   = bot && right;
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_pos   = r_pos;
        n_ocol  = r_ocol;
        n_orow  = r_orow;
        n_extra = r_extra;
        if (i_restart) begin
            n_col   = '0;
            n_row   = '0;
            n_pos   = '0;
            n_ocol  = '0;
            n_orow  = '0;
            n_extra = 1'b0;
        end else if (is_pos) begin
            if (r_extra) begin
                n_extra = 1'b0;
            end else if (i_item.is_drain && !emit) begin
                // A drain that releases nothing processes a second position.
                n_extra = 1'b1;
            end
            n_pos = r_pos + POS_W'(1);
            if ((WID_W'(r_col) + WID_W'(1)) >= w) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
            if (emit) begin
                if (bot && right) begin
                    n_col  = '0;
                    n_row  = '0;
                    n_pos  = '0;
                    n_ocol = '0;
                    n_orow = '0;
                end else if (right) begin
                    n_ocol = '0;
                    n_orow = r_orow + ROW_W'(1);
                end else begin
                    n_ocol = r_ocol + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_pos   <= '0;
            r_ocol  <= '0;
            r_orow  <= '0;
            r_extra <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_pos   <= n_pos;
            r_ocol  <= n_ocol;
            r_orow  <= n_orow;
            r_extra <= n_extra;
        end
    end

    assign o_stat.extra    = r_extra;
    assign o_stat.pos_zero = r_pos == '0;

endmodule

[rtl/core/rgbc_opq.sv]
// Short queue of classified positions between the front and back ends.
module rgbc_opq import rgbc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_op  o_head
);

    t_op                r_mem [OPQ_DEPTH];
    logic [OPQ_AW-1:0]  r_wr, r_rd;
    logic [OPQ_AW:0]    r_cnt, n_cnt;
    logic               do_push, do_pop;

    assign o_full  = r_cnt == (OPQ_AW+1)'(OPQ_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (OPQ_AW+1)'(1);
        end else if (!do_push && do_pop) begin
            n_cnt = r_cnt - (OPQ_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= r_wr + OPQ_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + OPQ_AW'(1);
            end
        end
    end

endmodule

[rtl/core/rgbc_back.sv]
// Back end: line stores, window, multiply-accumulate pipeline and result queue.
module rgbc_back import rgbc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_op              i_q_head,
    output logic             o_q_pop,
    input  logic [CFG_W-1:0] i_kern [3],
    input  logic             pop,
    output logic             empty,
    output t_out_item        o_result,
    output t_back_stat       o_stat
);

    t_pix r_prev_mem [MAX_WIDTH];
    t_pix r_old_mem  [MAX_WIDTH];
    t_pix r_prev_q, r_old_q;

    logic r_a_v;
    t_op  r_a;
    logic             r_wa_v;
    logic [COL_W-1:0] r_wa_addr;
    t_pix             r_wa_px, r_wa_old;
    t_pix prev_px, old_px;

    t_pix r_win [3][3];
    logic r_b_emit, r_b_top, r_b_bot, r_b_left, r_b_right, r_b_eof;

    logic signed [PROD_W-1:0] r_prod [3][3][3];
    logic r_c_emit, r_c_eof;
    logic signed [RSUM_W-1:0] r_rsum [3][3];
    logic r_d_emit, r_d_eof;

    logic [1:0] rs [3];
    logic [1:0] cs [3];
    logic signed [SUM_W-1:0] tot [3];

    t_out_item          r_oq [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_owr, r_ord;
    logic [CRED_W-1:0]  r_ocnt, r_credit, n_credit;
    logic               do_opop;
    t_out_item          res;

    assign o_q_pop = !i_q_empty && (r_credit < CRED_W'(OUTQ_DEPTH));
    assign do_opop = pop && !empty;
    assign empty   = r_ocnt == '0;
    assign o_result = r_oq[r_ord];

    // Line store read; the write goes in the cycle after.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_prev_q <= r_prev_mem[i_q_head.addr];
            r_old_q  <= r_old_mem[i_q_head.addr];
        end
        if (r_a_v) begin
            r_prev_mem[r_a.addr] <= r_a.px;
            r_old_mem[r_a.addr]  <= prev_px;
        end
    end

    // Forward the write that coincided with this op's read.
    always_comb begin
        if (r_wa_v && r_wa_addr == r_a.addr) begin
            prev_px = r_wa_px;
            old_px  = r_wa_old;
        end else begin
            prev_px = r_prev_q;
            old_px  = r_old_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a       <= i_q_head;
        r_wa_addr <= r_a.addr;
        r_wa_px   <= r_a.px;
        r_wa_old  <= prev_px;
        if (r_a_v) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= old_px;
            r_win[1][2] <= prev_px;
            r_win[2][2] <= r_a.px;
        end
        r_b_top   <= r_a.top;
        r_b_bot   <= r_a.bot;
        r_b_left  <= r_a.left;
        r_b_right <= r_a.right;
        r_b_eof   <= r_a.eof;
    end

    always_comb begin
        rs[0] = r_b_top ? 2'd1 : 2'd0;
        rs[1] = 2'd1;
        rs[2] = r_b_bot ? 2'd1 : 2'd2;
        cs[0] = r_b_left ? 2'd1 : 2'd0;
        cs[1] = 2'd1;
        cs[2] = r_b_right ? 2'd1 : 2'd2;
    end

    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_prod[ch][i][j] <= $signed(i_kern[i][16*j +: 16])
                        * $signed({1'b0, r_win[rs[i]][cs[j]][16-8*ch +: 8]});
                end
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
                r_rsum[ch][i] <= RSUM_W'(r_prod[ch][i][0]) + RSUM_W'(r_prod[ch][i][1])
                                 + RSUM_W'(r_prod[ch][i][2]);
            end
        end
        r_c_eof <= r_b_eof;
        r_d_eof <= r_c_eof;
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            tot[ch] = SUM_W'(r_rsum[ch][0]) + SUM_W'(r_rsum[ch][1]) + SUM_W'(r_rsum[ch][2]);
        end
        res.red_out      = clamp_sum(tot[0]);
        res.green_out    = clamp_sum(tot[1]);
        res.blue_out     = clamp_sum(tot[2]);
        res.end_of_frame = r_d_eof;
    end

    always_ff @(posedge i_clk) begin
        if (r_d_emit) begin
            r_oq[r_owr] <= res;
        end
    end

    always_comb begin
        n_credit = r_credit;
        if (o_q_pop && i_q_head.emit) begin
            n_credit = n_credit + CRED_W'(1);
        end
        if (do_opop) begin
            n_credit = n_credit - CRED_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v    <= 1'b0;
            r_wa_v   <= 1'b0;
            r_b_emit <= 1'b0;
            r_c_emit <= 1'b0;
            r_d_emit <= 1'b0;
            r_owr    <= '0;
            r_ord    <= '0;
            r_ocnt   <= '0;
            r_credit <= '0;
        end else begin
            r_a_v    <= o_q_pop;
            r_wa_v   <= r_a_v;
            r_b_emit <= r_a_v && r_a.emit;
            r_c_emit <= r_b_emit;
            r_d_emit <= r_c_emit;
            r_credit <= n_credit;
            if (r_d_emit) begin
                r_owr <= r_owr + OUTQ_AW'(1);
            end
            if (do_opop) begin
                r_ord <= r_ord + OUTQ_AW'(1);
            end
            if (r_d_emit && !do_opop) begin
                r_ocnt <= r_ocnt + CRED_W'(1);
            end else if (!r_d_emit && do_opop) begin
                r_ocnt <= r_ocnt - CRED_W'(1);
            end
        end
    end

    assign o_stat.credit = r_credit;

endmodule

[rtl/core/rgb_convolution_3x3.sv]
// Top level of the streaming 3x3 RGB convolution block.
//
//  Channel   Direction  Handshake                   Payload
//  input     in         push / full                 i_item (t_in_item)
//  result    out        empty / pop                 o_result (t_out_item)
//  config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// While full is low, one transaction is accepted per cycle on the input side; the rate is
// set by the single read/write port pair of the line stores, which each position uses once.
// A position leaves the internal queue and passes through five stages before its result is
// written into the output queue; the stages are line store read, window update,
// multiply, row sums, final sum and clamp.
// Reset is synchronous; it clears counters, queues and valid flags but no line store.
// A drain that releases nothing takes a second position, during which full stays high.
// When eight results are waiting or in flight, the back end stops and the input side fills.
`include "rgb_convolution_3x3_assert.svh"

module rgb_convolution_3x3 import rgbc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  t_in_item         i_item,
    output logic             empty,
    input  logic             pop,
    output t_out_item        o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // Configuration registers. The kernel rows hold three signed Q8.8
    // coefficients each, the left one in the low sixteen bits.
    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;
    logic [CFG_W-1:0] r_kern [3];
    logic             cfg_we, restart;

    t_op         q_op, q_head;
    logic        q_push, q_full, q_empty, q_pop;
    t_front_stat front_stat;
    t_back_stat  back_stat;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Writing either geometry register restarts the frame.
    assign restart = cfg_we && (i_cfg_index inside {CFG_WIDTH, CFG_HEIGHT});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WID_W'(640);
            r_height  <= HGT_W'(480);
            r_kern[0] <= '0;
            r_kern[1] <= CFG_W'(48'h0000_0100_0000);
            r_kern[2] <= '0;
        end else if (cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WIDTH:  r_width   <= i_cfg_data[WID_W-1:0];
                CFG_HEIGHT: r_height  <= i_cfg_data[HGT_W-1:0];
                CFG_K_TOP:  r_kern[0] <= i_cfg_data;
                CFG_K_MID:  r_kern[1] <= i_cfg_data;
                CFG_K_BOT:  r_kern[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front end decides for each transaction whether it is a stream
    // position, and which output and border case that position produces.
    rgbc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_restart (restart),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_op    (q_op),
        .o_stat    (front_stat)
    );

    rgbc_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // The back end owns the line stores and the arithmetic and reserves a
    // result slot for every position that will produce a result.
    rgbc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .i_kern    (r_kern),
        .pop       (pop),
        .empty     (empty),
        .o_result  (o_result),
        .o_stat    (back_stat)
    );

    // The second position of a drain blocks new transactions.
    `RGBC_ASSERT_IMPL(a_extra_blocks, i_clk, i_rst_n, front_stat.extra, full)
    // A geometry write leaves the stream position at the frame start.
    `RGBC_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, restart, front_stat.pos_zero)
    // Reservations never exceed the result queue.
    `RGBC_ASSERT_IMPL(a_credit_bound, i_clk, i_rst_n, 1'b1, back_stat.credit <= CRED_W'(OUTQ_DEPTH))
    // Every waiting result holds a reservation.
    `RGBC_ASSERT_IMPL(a_result_reserved, i_clk, i_rst_n, !empty, back_stat.credit != '0)

endmodule
